>>> sv/gkcs_pkg.sv
// ----------------------------------------------------------------------------
// gkcs_pkg
// Shared widths, types and the reset value for the graph coloring search block.
// ----------------------------------------------------------------------------
package gkcs_pkg;

  localparam int unsigned ROW_W   = 16;
  localparam int unsigned COLOR_W = 5;
  localparam int unsigned TRY_W   = COLOR_W + 1;

  localparam logic [COLOR_W-1:0] NUM_COLORS_RST = 5'd3;

  typedef logic [ROW_W-1:0]   row_t;
  typedef logic [COLOR_W-1:0] color_t;
  typedef logic [TRY_W-1:0]   try_t;

endpackage

>>> sv/graph_k_coloring_search.sv
// Each accepted row within the vertex limit is stored; a non-final row gives no result.
// After the final row, S_CLEAR zeroes the color store for the rows loaded, then the
// search runs: S_FETCH and S_FWAIT fetch a vertex, S_TRY tries each color, S_SCAN_RD and
// S_SCAN_CMP check each vertex index against it, S_SCAN_RD places it; data dependent, result registered.
// Throughput: one row per cycle while loading; no input during a search or
// while a result waits. Async active-low reset clears control, num_colors=3.
// ----------------------------------------------------------------------------
// graph_k_coloring_search
// Loads adjacency rows, then decides k-colorability by backtracking search.
// ----------------------------------------------------------------------------
module graph_k_coloring_search #(
  parameter int unsigned MAX_VERTICES = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [gkcs_pkg::COLOR_W-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [gkcs_pkg::ROW_W-1:0]   in_row_bits_i,
  input  logic                         in_last_row_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_colorable_o,
  output logic                         out_row_overflow_o
);

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned SCAN_MAX =
    (MAX_VERTICES < gkcs_pkg::ROW_W) ? MAX_VERTICES : gkcs_pkg::ROW_W;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLEAR,
    S_FETCH,
    S_FWAIT,
    S_TRY,
    S_SCAN_RD,
    S_SCAN_CMP
  } state_e;

  state_e                  state_q;
  gkcs_pkg::color_t        num_colors_q;
  logic [CW-1:0]           rows_q;
  logic [CW-1:0]           v_q;
  logic [CW-1:0]           i_q;
  logic                    ovf_q;
  gkcs_pkg::try_t          c_q;
  gkcs_pkg::row_t          row_q;
  gkcs_pkg::row_t          sh_q;
  logic                    out_valid_q;
  logic                    out_colorable_q;
  logic                    out_ovf_q;

  gkcs_pkg::row_t          adj_mem [MAX_VERTICES];
  gkcs_pkg::row_t          adj_rdata_q;
  gkcs_pkg::color_t        col_mem [MAX_VERTICES];
  gkcs_pkg::color_t        col_rdata_q;

  logic                    in_acc;
  logic                    adj_we;
  logic                    col_we;
  logic [VW-1:0]           col_waddr;
  gkcs_pkg::color_t        col_wdata;
  logic [VW-1:0]           col_raddr;
  logic [CW-1:0]           lim;
  logic [CW-1:0]           v_inc;
  logic                    c_over;
  logic                    found;

  assign in_stall_o = (state_q != S_LOAD) || out_valid_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adj_we     = in_acc && (rows_q < CW'(MAX_VERTICES));
  assign lim        = (rows_q < CW'(SCAN_MAX)) ? rows_q : CW'(SCAN_MAX);
  assign v_inc      = v_q + CW'(1);
  assign c_over     = c_q > {1'b0, num_colors_q};
  assign found      = (state_q == S_SCAN_RD) && (i_q == lim);

  always_comb begin
    col_we    = 1'b0;
    col_waddr = v_q[VW-1:0];
    col_wdata = '0;
    col_raddr = v_q[VW-1:0];
    case (state_q)
      S_CLEAR: begin
        col_we    = 1'b1;
        col_waddr = i_q[VW-1:0];
      end
      S_TRY: begin
        col_we = c_over;
      end
      S_SCAN_RD: begin
        col_raddr = i_q[VW-1:0];
        col_we    = found;
        col_wdata = c_q[gkcs_pkg::COLOR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[rows_q[VW-1:0]] <= in_row_bits_i;
    end
    adj_rdata_q <= adj_mem[v_q[VW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (col_we) begin
      col_mem[col_waddr] <= col_wdata;
    end
    col_rdata_q <= col_mem[col_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_LOAD;
      num_colors_q    <= gkcs_pkg::NUM_COLORS_RST;
      rows_q          <= '0;
      v_q             <= '0;
      i_q             <= '0;
      ovf_q           <= 1'b0;
      c_q             <= '0;
      row_q           <= '0;
      sh_q            <= '0;
      out_valid_q     <= 1'b0;
      out_colorable_q <= 1'b0;
      out_ovf_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_colors_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (adj_we) begin
              rows_q <= rows_q + CW'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_last_row_i) begin
              i_q     <= '0;
              state_q <= S_CLEAR;
            end
          end
        end
        S_CLEAR: begin
          i_q <= i_q + CW'(1);
          if (i_q == rows_q - CW'(1)) begin
            v_q     <= '0;
            state_q <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_q <= S_FWAIT;
        end
        S_FWAIT: begin
          row_q   <= adj_rdata_q;
          c_q     <= {1'b0, col_rdata_q} + gkcs_pkg::TRY_W'(1);
          state_q <= S_TRY;
        end
        S_TRY: begin
          if (c_over) begin
            if (v_q == '0) begin
              out_valid_q     <= 1'b1;
              out_colorable_q <= 1'b0;
              out_ovf_q       <= ovf_q;
              ovf_q           <= 1'b0;
              rows_q          <= '0;
              state_q         <= S_LOAD;
            end else begin
              v_q     <= v_q - CW'(1);
              state_q <= S_FETCH;
            end
          end else begin
            i_q     <= '0;
            sh_q    <= row_q;
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (found) begin
            v_q <= v_inc;
            if (v_inc == rows_q) begin
              out_valid_q     <= 1'b1;
              out_colorable_q <= 1'b1;
              out_ovf_q       <= ovf_q;
              ovf_q           <= 1'b0;
              rows_q          <= '0;
              state_q         <= S_LOAD;
            end else begin
              state_q <= S_FETCH;
            end
          end else begin
            state_q <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (sh_q[0] && ({1'b0, col_rdata_q} == c_q)) begin
            c_q     <= c_q + gkcs_pkg::TRY_W'(1);
            state_q <= S_TRY;
          end else begin
            i_q     <= i_q + CW'(1);
            sh_q    <= sh_q >> 1;
            state_q <= S_SCAN_RD;
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_colorable_o    = out_colorable_q;
  assign out_row_overflow_o = out_ovf_q;

  a_rows_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q <= CW'(MAX_VERTICES))
    else $error("row count beyond vertex limit");

  a_vertex_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_LOAD && state_q != S_CLEAR) |-> (v_q < rows_q))
    else $error("search vertex outside loaded graph");

  a_color_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_RD || state_q == S_SCAN_CMP) |->
      (c_q != '0 && c_q <= {1'b0, num_colors_q}))
    else $error("scanned color out of range");

  a_result_from_search : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == S_TRY || $past(state_q) == S_SCAN_RD))
    else $error("result item without a finished search");

endmodule
